// File: design/dpm_pkg.sv
// Package for the dithered palette mapper: constants, codes, shared types
// and the per-channel distance helper. No dependencies.
`default_nettype none

package dpm_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WIDTH_DEF     = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int ERROR_LIMIT_DEF   = 20;

    // Stream and configuration port widths
    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int WIDTH_CFG_W = 13;
    localparam int PSIZE_CFG_W = 9;

    localparam logic [WIDTH_CFG_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [PSIZE_CFG_W-1:0] PSIZE_RESET = 9'd256;

    // Squared distance: 3 x 255^2 fits in 18 bits; start value beats every real distance
    localparam int              DIST_W    = 18;
    localparam logic [DIST_W-1:0] DIST_INIT = 18'd200000;

    // Adjusted pixel before clamping: 8-bit input plus a half error of at most 8 bits
    localparam int         ADJ_W    = 11;
    localparam logic [7:0] CHAN_MAX = 8'd255;
    localparam logic [7:0] BIN_MASK = 8'd248;
    localparam logic [7:0] BIN_HALF = 8'd4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_PALETTE_SIZE = 1'b1
    } cfg_idx_t;

    // Request kinds carried in tuser
    typedef enum logic {
        REQ_PAL_WRITE = 1'b0,
        REQ_PIXEL     = 1'b1
    } req_type_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADJUST,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Control from the sequencer to the distance unit
    typedef struct packed {
        logic start;   // reset the running minimum
        logic vld;     // a palette entry is presented this cycle
    } dist_ctl_t;

    // Center of the 5-bit bin a channel value falls in
    function automatic logic [7:0] bin_center(input logic [7:0] c);
        return (c & BIN_MASK) + BIN_HALF;
    endfunction

    // Squared difference of one channel
    function automatic logic [DIST_W-1:0] chan_sq(input logic [7:0] p, input logic [7:0] c);
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        diff = signed'({1'b0, p}) - signed'({1'b0, c});
        prod = diff * diff;
        return DIST_W'(unsigned'(prod));
    endfunction

endpackage

`default_nettype wire

// File: design/dpm_dist_unit.sv
// Shared distance unit: squared RGB distance of one palette entry per cycle,
// registered, then compared against the running minimum. Uses dpm_pkg.
`default_nettype none

module dpm_dist_unit #(
    parameter int PA_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dpm_pkg::dist_ctl_t  ctl,
    input  logic [PA_W-1:0]     entry_idx,
    input  dpm_pkg::rgb_t       entry_rgb,
    input  dpm_pkg::rgb_t       center,
    output logic [PA_W-1:0]     best_idx,
    output dpm_pkg::rgb_t       best_rgb,
    output logic                busy
);
    import dpm_pkg::*;

    logic              d_vld_reg;
    logic [DIST_W-1:0] d_reg;
    logic [DIST_W-1:0] dist_next;
    logic [PA_W-1:0]   d_idx_reg;
    rgb_t              d_rgb_reg;

    logic [DIST_W-1:0] best_min_reg;
    logic [PA_W-1:0]   best_idx_reg;
    rgb_t              best_rgb_reg;
    logic              take_best;

    // Stage 1: distance of the presented entry
    assign dist_next = chan_sq(entry_rgb.red,   center.red)
                     + chan_sq(entry_rgb.green, center.green)
                     + chan_sq(entry_rgb.blue,  center.blue);

    // Stage 2: strict less-than keeps the lowest index on a tie
    assign take_best = d_vld_reg && (d_reg < best_min_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg    <= 1'b0;
            best_min_reg <= DIST_INIT;
        end
        else
        begin
            d_vld_reg <= ctl.vld;
            if (ctl.start)
                best_min_reg <= DIST_INIT;
            else if (take_best)
                best_min_reg <= d_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            d_reg     <= dist_next;
            d_idx_reg <= entry_idx;
            d_rgb_reg <= entry_rgb;
        end
        if (take_best)
        begin
            best_idx_reg <= d_idx_reg;
            best_rgb_reg <= d_rgb_reg;
        end
    end

    assign best_idx = best_idx_reg;
    assign best_rgb = best_rgb_reg;
    assign busy     = d_vld_reg;

endmodule

`default_nettype wire

// File: design/dpm_err_line.sv
// Error line memory: one entry of three signed channel errors per column,
// registered read, one write port, zero-fill sweep after reset. Uses dpm_pkg.
`default_nettype none

module dpm_err_line #(
    parameter int MAX_WIDTH = 4096,
    parameter int ERR_W     = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic [3*ERR_W-1:0]           rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [3*ERR_W-1:0]           wr_data,
    output logic                         busy
);
    import dpm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ENT_W = 3 * ERR_W;

    logic [ENT_W-1:0] err_mem [MAX_WIDTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic             clr_busy_reg;
    logic [COL_W-1:0] clr_addr_reg;

    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;

    // Zero-fill sweep, one column per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1))
                clr_busy_reg <= 1'b0;
            else
                clr_addr_reg <= clr_addr_reg + COL_W'(1);
        end
    end

    // Write port shared by the sweep and the sequencer
    assign mem_we    = clr_busy_reg || wr_en;
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : wr_addr;
    assign mem_wdata = clr_busy_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            err_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= err_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

`default_nettype wire

// File: design/dithered_palette_mapper.sv
// Top level of the dithered palette mapper: sequencer, palette memory and
// pixel error math. Uses dpm_pkg, dpm_dist_unit and dpm_err_line.
`default_nettype none

// Maps serpentine-ordered RGB888 pixels to palette indices with two-neighbor
// error diffusion. A palette write beat leaves the block ready again right
// after it. For a pixel beat, with n the number of palette entries searched
// (palette_size saturated to PALETTE_DEPTH, at least one), the adjusted pixel
// is formed, the single distance unit reads the n entries from the palette
// memory, one per cycle, the read and distance pipeline drains, and the errors
// are written back once the output register is free. After reset the error
// line memory is zero-filled across all MAX_WIDTH columns (4096 at the
// default) before the first beat is taken; configuration writes are taken at
// any time. A finished index waits in an output register, so the next pixel
// is searched while it is still unclaimed.
module dithered_palette_mapper #(
    parameter int MAX_WIDTH     = dpm_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_DEPTH = dpm_pkg::PALETTE_DEPTH_DEF,
    parameter int ERROR_LIMIT   = dpm_pkg::ERROR_LIMIT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dpm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [dpm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: pal_addr[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [dpm_pkg::IN_DATA_W-1:0]    s_tdata,
    // s_tuser: req_type[0], frame_start[1]
    input  logic [dpm_pkg::IN_USER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: color_index[7:0]
    output logic [dpm_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import dpm_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WV_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WV_W > WIDTH_CFG_W) ? WV_W : WIDTH_CFG_W;
    localparam int PA_W  = $clog2(PALETTE_DEPTH);
    localparam int NC_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int ERR_W = $clog2(ERROR_LIMIT + 1) + 1;
    localparam int ENT_W = 3 * ERR_W;
    localparam logic signed [9:0] ERR_LIM = 10'(ERROR_LIMIT);

    // Input beat fields
    logic       req_type;
    logic       frame_start;
    logic [7:0] pal_addr;
    rgb_t       in_rgb;

    assign req_type    = s_tuser[0];
    assign frame_start = s_tuser[1];
    assign pal_addr    = s_tdata[7:0];
    assign in_rgb      = '{red: s_tdata[15:8], green: s_tdata[23:16], blue: s_tdata[31:24]};

    logic accept;
    logic pix_acc;
    logic pal_wr_en;

    // Configuration
    logic [WIDTH_CFG_W-1:0] width_cfg_reg;
    logic [PSIZE_CFG_W-1:0] psize_cfg_reg;
    logic [WV_W-1:0]        w_eff;
    logic [NC_W-1:0]        n_eff;

    // Sequencer and row state
    state_t           state_reg;
    state_t           state_next;
    logic [COL_W-1:0] col_cnt_reg;
    logic             first_row_reg;
    logic             row_odd_reg;
    logic [NC_W-1:0]  issue_cnt_reg;
    logic             pal_rd_en;
    logic             upd_fire;
    logic             row_end;

    // Accept-time position
    logic             first_eff;
    logic             odd_eff;
    logic [COL_W-1:0] cnt_eff;
    logic [COL_W-1:0] pos_next;
    logic [COL_W-1:0] col_next;
    logic [COL_W-1:0] pos_reg;
    logic [COL_W-1:0] col_reg;

    // Pixel payload
    rgb_t       in_rgb_reg;
    rgb_t       pix_reg;
    rgb_t       pix_next;
    logic [7:0] in_ch [3];
    logic [7:0] pix_ch [3];
    logic [7:0] pix_ch_next [3];
    logic [7:0] best_ch [3];
    logic [ENT_W-1:0] left_err_reg;
    logic [ENT_W-1:0] err_next;

    // Palette memory
    rgb_t            pal_mem [PALETTE_DEPTH];
    rgb_t            pal_q_reg;
    logic [PA_W-1:0] pal_q_idx_reg;
    logic            pal_q_vld_reg;

    // Distance unit and error line
    dist_ctl_t        dist_ctl;
    rgb_t             center;
    logic [PA_W-1:0]  best_idx;
    rgb_t             best_rgb;
    logic             dist_busy;
    logic [ENT_W-1:0] err_rd_data;
    logic             clr_busy;

    // Output register
    logic            out_vld_reg;
    logic [PA_W-1:0] out_idx_reg;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign pix_acc   = accept && (req_type == REQ_PIXEL);
    assign pal_wr_en = accept && (req_type == REQ_PAL_WRITE)
                       && ({1'b0, pal_addr} < 9'(PALETTE_DEPTH));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= WIDTH_RESET;
            psize_cfg_reg <= PSIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_IMAGE_WIDTH:  width_cfg_reg <= cfg_wdata[WIDTH_CFG_W-1:0];
                CFG_PALETTE_SIZE: psize_cfg_reg <= cfg_wdata[PSIZE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated row width
    always_comb
    begin
        if (width_cfg_reg == '0)
            w_eff = WV_W'(1);
        else if (CMP_W'(width_cfg_reg) > CMP_W'(MAX_WIDTH))
            w_eff = WV_W'(MAX_WIDTH);
        else
            w_eff = WV_W'(width_cfg_reg);
    end

    // Entries to search; an empty palette still probes entry 0
    always_comb
    begin
        if (psize_cfg_reg == '0)
            n_eff = NC_W'(1);
        else if (psize_cfg_reg > PSIZE_CFG_W'(PALETTE_DEPTH))
            n_eff = NC_W'(PALETTE_DEPTH);
        else
            n_eff = NC_W'(psize_cfg_reg);
    end

    // Column of the accepted pixel, after a frame start is applied
    always_comb
    begin
        first_eff = frame_start ? 1'b1 : first_row_reg;
        odd_eff   = frame_start ? 1'b0 : row_odd_reg;
        cnt_eff   = frame_start ? '0 : col_cnt_reg;
        if (WV_W'(cnt_eff) < w_eff)
            pos_next = cnt_eff;
        else
            pos_next = COL_W'(w_eff - WV_W'(1));
        if (odd_eff)
            col_next = COL_W'(w_eff - WV_W'(1) - WV_W'(pos_next));
        else
            col_next = pos_next;
    end

    assign row_end = (WV_W'(pos_reg) + WV_W'(1)) >= w_eff;

    // Channel views
    assign in_ch[0]   = in_rgb_reg.red;
    assign in_ch[1]   = in_rgb_reg.green;
    assign in_ch[2]   = in_rgb_reg.blue;
    assign pix_ch[0]  = pix_reg.red;
    assign pix_ch[1]  = pix_reg.green;
    assign pix_ch[2]  = pix_reg.blue;
    assign best_ch[0] = best_rgb.red;
    assign best_ch[1] = best_rgb.green;
    assign best_ch[2] = best_rgb.blue;

    // Adjusted pixel: input plus floor of half the above and left errors, clamped
    always_comb
    begin
        logic signed [ERR_W-1:0] above;
        logic signed [ERR_W-1:0] left;
        logic signed [ERR_W:0]   esum;
        logic signed [ERR_W:0]   ehalf;
        logic signed [ADJ_W-1:0] adj;
        for (int c = 0; c < 3; c++)
        begin
            above = first_row_reg ? '0 : err_rd_data[c*ERR_W +: ERR_W];
            left  = (pos_reg == '0) ? '0 : left_err_reg[c*ERR_W +: ERR_W];
            esum  = (ERR_W+1)'(above) + (ERR_W+1)'(left);
            ehalf = esum >>> 1;
            adj   = ADJ_W'(signed'({1'b0, in_ch[c]})) + ADJ_W'(ehalf);
            if (adj < 0)
                pix_ch_next[c] = '0;
            else if (adj > ADJ_W'(signed'({1'b0, CHAN_MAX})))
                pix_ch_next[c] = CHAN_MAX;
            else
                pix_ch_next[c] = adj[7:0];
        end
    end

    assign pix_next = '{red: pix_ch_next[0], green: pix_ch_next[1], blue: pix_ch_next[2]};

    // New errors against the chosen entry, clamped to the limit
    always_comb
    begin
        logic signed [9:0] diff;
        logic signed [9:0] ecl;
        for (int c = 0; c < 3; c++)
        begin
            diff = signed'({2'b00, pix_ch[c]}) - signed'({2'b00, best_ch[c]});
            if (diff > ERR_LIM)
                ecl = ERR_LIM;
            else if (diff < -ERR_LIM)
                ecl = -ERR_LIM;
            else
                ecl = diff;
            err_next[c*ERR_W +: ERR_W] = ERR_W'(ecl);
        end
    end

    // Sequencer: next state and strobes
    always_comb
    begin
        state_next = state_reg;
        pal_rd_en  = 1'b0;
        upd_fire   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (!clr_busy)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (pix_acc)
                    state_next = ST_ADJUST;
            end
            ST_ADJUST:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (issue_cnt_reg < n_eff)
                    pal_rd_en = 1'b1;
                else if (!pal_q_vld_reg && !dist_busy)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    upd_fire   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // Row, search and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg   <= '0;
            first_row_reg <= 1'b1;
            row_odd_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            pal_q_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (pix_acc)
            begin
                first_row_reg <= first_eff;
                row_odd_reg   <= odd_eff;
                col_cnt_reg   <= cnt_eff;
            end
            else if (upd_fire)
            begin
                if (row_end)
                begin
                    col_cnt_reg   <= '0;
                    row_odd_reg   <= !row_odd_reg;
                    first_row_reg <= 1'b0;
                end
                else
                begin
                    col_cnt_reg <= pos_reg + COL_W'(1);
                end
            end

            if (state_reg == ST_ADJUST)
                issue_cnt_reg <= '0;
            else if (pal_rd_en)
                issue_cnt_reg <= issue_cnt_reg + NC_W'(1);

            pal_q_vld_reg <= pal_rd_en;

            if (upd_fire)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // Pixel payload registers
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            pos_reg    <= pos_next;
            col_reg    <= col_next;
            in_rgb_reg <= in_rgb;
        end
        if (state_reg == ST_ADJUST)
            pix_reg <= pix_next;
        if (pal_rd_en)
            pal_q_idx_reg <= issue_cnt_reg[PA_W-1:0];
        if (upd_fire)
        begin
            left_err_reg <= err_next;
            out_idx_reg  <= best_idx;
        end
    end

    // Palette memory: write from palette beats, one read per search cycle
    always_ff @(posedge clk)
    begin
        if (pal_wr_en)
            pal_mem[pal_addr[PA_W-1:0]] <= in_rgb;
        if (pal_rd_en)
            pal_q_reg <= pal_mem[issue_cnt_reg[PA_W-1:0]];
    end

    assign center = '{red:   bin_center(pix_reg.red),
                      green: bin_center(pix_reg.green),
                      blue:  bin_center(pix_reg.blue)};

    assign dist_ctl = '{start: (state_reg == ST_ADJUST), vld: pal_q_vld_reg};

    dpm_dist_unit #(
        .PA_W (PA_W)
    ) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (dist_ctl),
        .entry_idx (pal_q_idx_reg),
        .entry_rgb (pal_q_reg),
        .center    (center),
        .best_idx  (best_idx),
        .best_rgb  (best_rgb),
        .busy      (dist_busy)
    );

    dpm_err_line #(
        .MAX_WIDTH (MAX_WIDTH),
        .ERR_W     (ERR_W)
    ) u_err_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pix_acc),
        .rd_addr (col_next),
        .rd_data (err_rd_data),
        .wr_en   (upd_fire),
        .wr_addr (col_reg),
        .wr_data (err_next),
        .busy    (clr_busy)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = OUT_DATA_W'(out_idx_reg);

endmodule

`default_nettype wire

// File: design/dpm_checker.sv
// Port-level checker for the dithered palette mapper and its bind statement.
// Uses dpm_pkg; attaches to dithered_palette_mapper.
`default_nettype none

module dpm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [dpm_pkg::IN_USER_W-1:0]    s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dpm_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import dpm_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // A pixel beat occupies the sequencer
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == REQ_PIXEL) |=> !s_tready)
        else $error("ready after a pixel beat");

    // A palette write leaves the block ready again right after it
    a_palwr_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == REQ_PAL_WRITE) |=> s_tready)
        else $error("not ready after a palette write beat");

    // A new result only comes out of the write-back step, never from idle
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while idle");

endmodule

bind dithered_palette_mapper dpm_checker u_dpm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: sim/dithered_palette_mapper_tb.sv
// Self-checking testbench for dithered_palette_mapper: a scoreboard class predicts the
// palette index of every pixel beat, plain tasks drive stream beats and register writes.
// Depends on dpm_pkg and the dithered_palette_mapper RTL.

module dithered_palette_mapper_tb;
    import dpm_pkg::*;

    // Predicts dithered palette indices and checks the result stream against them
    class palette_index_checker;
        rgb_t        palette [256];
        int          above_err [4096][3];
        int          left_err [3];
        int          col_count;
        bit          first_row;
        bit          row_odd;
        logic [12:0] width_reg;
        logic [8:0]  psize_reg;
        logic [7:0]  expected_index_q [$];
        int          mismatches;
        int          pixels;
        int          writes;

        function new();
            width_reg = WIDTH_RESET;
            psize_reg = PSIZE_RESET;
            foreach (above_err[i, j])
                above_err[i][j] = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            col_count = 0;
            first_row = 1'b1;
            row_odd   = 1'b0;
            foreach (left_err[c])
                left_err[c] = 0;
        endfunction

        function int level(rgb_t color, int ch);
            case (ch)
                0:       return color.red;
                1:       return color.green;
                default: return color.blue;
            endcase
        endfunction

        function int clip(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void set_reg(cfg_idx_t idx, int value);
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = value[12:0];
            else
                psize_reg = value[8:0];
        endfunction

        function int pending();
            return expected_index_q.size();
        endfunction

        // Accepted input beat: update the palette or map one pixel
        function void note_beat(req_type_t kind, logic [7:0] addr, rgb_t color,
                                logic frame_first);
            int w;
            int pos;
            int col;
            int n;
            int best;
            int min_dist;
            int d;
            int diff;
            int err_sum;
            int e;
            int pix [3];
            if (kind == REQ_PAL_WRITE)
            begin
                palette[addr] = color;
                writes++;
                return;
            end
            if (frame_first)
                restart_frame();

            w   = clip(width_reg, 1, 4096);
            pos = (col_count < w) ? col_count : w - 1;
            col = row_odd ? (w - 1 - pos) : pos;

            // adjusted pixel: input plus floor half of above + left error
            for (int ch = 0; ch < 3; ch++)
            begin
                err_sum = (first_row ? 0 : above_err[col][ch])
                          + ((pos == 0) ? 0 : left_err[ch]);
                pix[ch] = clip(level(color, ch) + (err_sum >>> 1), 0, 255);
            end

            // nearest entry to the bin center, lowest index wins a tie
            n        = (psize_reg > 256) ? 256 : psize_reg;
            best     = 0;
            min_dist = 200000;
            for (int i = 0; i < n; i++)
            begin
                d = 0;
                for (int ch = 0; ch < 3; ch++)
                begin
                    diff = level(palette[i], ch) - ((pix[ch] & 248) + 4);
                    d += diff * diff;
                end
                if (d < min_dist)
                begin
                    min_dist = d;
                    best     = i;
                end
            end

            for (int ch = 0; ch < 3; ch++)
            begin
                e = clip(pix[ch] - level(palette[best], ch), -20, 20);
                above_err[col][ch] = e;
                left_err[ch]       = e;
            end

            // serpentine row advance
            if (pos + 1 >= w)
            begin
                col_count = 0;
                row_odd   = !row_odd;
                first_row = 1'b0;
                foreach (left_err[c])
                    left_err[c] = 0;
            end
            else
                col_count = pos + 1;

            pixels++;
            expected_index_q.push_back(best[7:0]);
        endfunction

        // Accepted result beat: compare with the oldest prediction
        function void check_index(logic [7:0] actual);
            logic [7:0] want;
            if (expected_index_q.size() == 0)
            begin
                $error("color_index: no result expected, got %0d", actual);
                mismatches++;
            end
            else
            begin
                want = expected_index_q.pop_front();
                if (actual !== want)
                begin
                    $error("color_index: expected %0d, got %0d", want, actual);
                    mismatches++;
                end
            end
        endfunction
    endclass

    localparam int QUIET_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 670;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_idx_t              cfg_addr  = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    palette_index_checker idx_check = new();

    bit tx_idle_on;
    bit rx_idle_on;
    int rx_stall_left;
    int quiet_cycles;
    int random_items;
    int settings_run;

    always #1 clk = ~clk;

    dithered_palette_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Receiver: ready drops in random bursts while idling is on
    always @(posedge clk)
    begin
        if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_stall_left = $urandom_range(0, 12);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            idx_check.check_index(m_tdata);
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("dithered_palette_mapper_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One input beat; valid stays high afterwards unless the caller lowers it
    task automatic send_beat(req_type_t kind, logic [7:0] addr, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b, logic frame_first);
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r, addr};
        s_tuser  <= {frame_first, kind};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        idx_check.note_beat(kind, addr, {r, g, b}, frame_first);
    endtask

    // Stop sending and let every predicted index come back, then let a write settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (idx_check.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // Write both registers; only called with no pixel beat in flight
    task automatic set_config(int width, int psize);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_IMAGE_WIDTH;
        cfg_wdata <= 13'(width);
        @(posedge clk);
        cfg_addr  <= CFG_PALETTE_SIZE;
        cfg_wdata <= 13'(psize & 'h1FF);
        @(posedge clk);
        cfg_we <= 1'b0;
        idx_check.set_reg(CFG_IMAGE_WIDTH, width);
        idx_check.set_reg(CFG_PALETTE_SIZE, psize);
        settings_run++;
    endtask

    initial
    begin
        int len;
        int width;
        int psize;
        bit last_phase;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Directed: tiny palette with duplicate entries for ties
        set_config(4, 4);
        send_beat(REQ_PAL_WRITE, 8'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_beat(REQ_PAL_WRITE, 8'd1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_beat(REQ_PAL_WRITE, 8'd2, 8'h08, 8'h00, 8'h00, 1'b0);
        send_beat(REQ_PAL_WRITE, 8'd3, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_beat(REQ_PAL_WRITE, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // tie between entries 0 and 2 on a fresh frame, then white ties 1 and 3
        send_beat(REQ_PIXEL, 8'd0, 8'd3, 8'd3, 8'd3, 1'b1);
        send_beat(REQ_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_beat(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_beat(REQ_PIXEL, 8'd170, 8'd255, 8'd0, 8'd0, 1'b0);
        // second row runs right to left and picks up the error line
        send_beat(REQ_PIXEL, 8'd85, 8'd0, 8'd255, 8'd0, 1'b0);
        send_beat(REQ_PIXEL, 8'd0, 8'd128, 8'd128, 8'd128, 1'b0);
        send_beat(REQ_PIXEL, 8'd0, 8'd250, 8'd5, 8'd130, 1'b0);
        send_beat(REQ_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
        wait_drained();
        set_config(6, 4);
        repeat (4) send_beat(REQ_PIXEL, 8'd0, rand_level(), rand_level(), rand_level(), 1'b0);
        // width lowered mid-row, empty palette search
        wait_drained();
        set_config(2, 0);
        send_beat(REQ_PIXEL, 8'd0, 8'd200, 8'd100, 8'd50, 1'b0);
        send_beat(REQ_PIXEL, 8'd0, 8'd1, 8'd254, 8'd127, 1'b0);
        // zero width acts as one column
        wait_drained();
        set_config(0, 1);
        send_beat(REQ_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1);
        send_beat(REQ_PIXEL, 8'd0, 8'd17, 8'd34, 8'd51, 1'b0);
        // oversize width saturates
        wait_drained();
        set_config(8191, 2);
        send_beat(REQ_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
        send_beat(REQ_PIXEL, 8'd0, 8'd9, 8'd9, 8'd9, 1'b1);

        // Fill the whole palette so every later setting reads written entries
        wait_drained();
        set_config(16, 16);
        for (int a = 0; a < 256; a++)
            send_beat(REQ_PAL_WRITE, 8'(a), rand_level(), rand_level(), rand_level(),
                      1'($urandom_range(0, 1)));

        // Random phases, one register setting each
        while (random_items < RANDOM_ITEMS)
        begin
            len        = $urandom_range(30, 90);
            last_phase = (RANDOM_ITEMS - random_items) <= len + 40;
            if (last_phase)
                len = RANDOM_ITEMS - random_items;
            case ($urandom_range(0, 9))
                0:       width = 0;
                1:       width = 1;
                2:       width = 3;
                3:       width = 4096;
                4:       width = 8191;
                default: width = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 11))
                0:       psize = 0;
                1:       psize = 1;
                2:       psize = 256;
                3:       psize = 511;
                4:       psize = 255;
                default: psize = $urandom_range(2, 24);
            endcase
            // full searches are slow: keep those phases short
            if (psize > 64)
            begin
                if (last_phase)
                    psize = $urandom_range(2, 24);
                else if (len > 25)
                    len = 25;
            end
            wait_drained();
            tx_idle_on = !last_phase && $urandom_range(0, 3) != 0;
            rx_idle_on = !last_phase && $urandom_range(0, 3) != 0;
            set_config(width, psize);
            repeat (len)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                if ($urandom_range(0, 6) == 0)
                    send_beat(REQ_PAL_WRITE, 8'($urandom_range(0, 255)), rand_level(),
                              rand_level(), rand_level(), 1'($urandom_range(0, 1)));
                else
                    send_beat(REQ_PIXEL, 8'($urandom_range(0, 255)), rand_level(),
                              rand_level(), rand_level(), $urandom_range(0, 39) == 0);
                random_items++;
            end
        end

        wait_drained();
        repeat (300) @(posedge clk);
        if (idx_check.pending() != 0)
        begin
            $error("color_index: %0d expected results never arrived", idx_check.pending());
            idx_check.mismatches++;
        end
        $display("Mapped %0d pixels with %0d palette writes across %0d register settings,",
                 idx_check.pixels, idx_check.writes, settings_run);
        $display("including zero and saturated sizes, ties, frame restarts and mid-row resizes.");
        if (idx_check.mismatches == 0)
            $display("dithered_palette_mapper_tb OK");
        else
            $display("dithered_palette_mapper_tb NOT OK");
        $finish;
    end
endmodule
